[rtl/swc_pkg.sv]
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the screen/world coordinate map
// Register indexes, status and operation codes, divider sidecar layout.
// ----------------------------------------------------------------------------
package swc_pkg;

    // Dividend and quotient width of the inverse path: (l - mid) * 2^16 magnitude
    localparam int QW  = 81;
    // Width of a rotated pixel value in the forward path
    localparam int RXW = 36;

    localparam logic [31:0] COS_RESET   = 32'h4000_0000;
    localparam logic [63:0] SCALE_RESET = 64'h0000_0001_0000_0000;

    typedef enum logic [2:0] {
        REG_WIN_WIDTH,
        REG_WIN_HEIGHT,
        REG_COS_TERM,
        REG_SIN_TERM,
        REG_X_UNITS,
        REG_Y_UNITS,
        REG_X_VIEW_MID,
        REG_Y_VIEW_MID
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SAT        = 2'd1,
        ST_ZERO_SCALE = 2'd2
    } status_t;

    typedef enum logic {
        OP_TO_LOGICAL = 1'b0,
        OP_TO_PIXEL   = 1'b1
    } op_t;

    // Travels alongside the divider lanes
    typedef struct packed {
        op_t                   op;
        logic                  neg_x;
        logic                  neg_y;
        logic signed [RXW-1:0] rx;
        logic signed [RXW-1:0] ry;
    } div_side_t;

endpackage

[rtl/swc_if.sv]
// ----------------------------------------------------------------------------
// swc_if: item channels of the coordinate map
// Point channel in, result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swc_point_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] in_px;
    logic signed [31:0] in_py;
    logic signed [63:0] in_lx;
    logic signed [63:0] in_ly;

    modport source (output valid, operation, in_px, in_py, in_lx, in_ly, input ready);
    modport sink   (input valid, operation, in_px, in_py, in_lx, in_ly, output ready);
endinterface

interface swc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_px;
    logic signed [31:0] out_py;
    logic signed [63:0] out_lx;
    logic signed [63:0] out_ly;
    logic [1:0]         status;

    modport source (output valid, out_px, out_py, out_lx, out_ly, status, input ready);
    modport sink   (input valid, out_px, out_py, out_lx, out_ly, status, output ready);
endinterface

[rtl/swc_mul.sv]
// ----------------------------------------------------------------------------
// swc_mul: two-stage signed multiplier, WA x 64 bits
// Splits the 64-bit operand in halves, registers partial products, then sums them.
// ----------------------------------------------------------------------------
module swc_mul #(
    parameter int WA = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [WA-1:0] a,
    input  logic signed [63:0]   b,
    output logic signed [WA+63:0] p
);

    logic signed [WA+32:0] lo_reg, lo_next;
    logic signed [WA+31:0] hi_reg, hi_next;
    logic signed [WA+63:0] p_reg, p_next;

    always_comb
    begin
        lo_next = a * $signed({1'b0, b[31:0]});
        hi_next = a * $signed(b[63:32]);
        p_next  = ($signed({{32{hi_reg[WA+31]}}, hi_reg}) <<< 32)
                + $signed({{31{lo_reg[WA+32]}}, lo_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/swc_div.sv]
// ----------------------------------------------------------------------------
// swc_div: pipelined restoring divider, two lanes, one quotient bit a stage
// Unsigned QW-bit dividends by 64-bit divisors; a sidecar rides along.
// ----------------------------------------------------------------------------
module swc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [swc_pkg::QW-1:0]    dvd_x,
    input  logic [swc_pkg::QW-1:0]    dvd_y,
    input  logic [63:0]               dvs_x,
    input  logic [63:0]               dvs_y,
    input  swc_pkg::div_side_t        in_side,
    output logic                      out_valid,
    output logic [swc_pkg::QW-1:0]    quo_x,
    output logic [swc_pkg::QW-1:0]    quo_y,
    output swc_pkg::div_side_t        out_side
);

    localparam int QW = swc_pkg::QW;

    logic                 vld_reg  [1:QW];
    swc_pkg::div_side_t   side_reg [1:QW];
    logic [QW-1:0]        mq_x_reg [1:QW];
    logic [QW-1:0]        mq_y_reg [1:QW];
    logic [63:0]          rem_x_reg [1:QW-1];
    logic [63:0]          rem_y_reg [1:QW-1];

    // {quotient bit, new remainder}
    function automatic logic [64:0] div_step(input logic [63:0] rem, input logic b,
                                             input logic [63:0] dvs);
        logic [64:0] sh;
        logic [64:0] diff;
        logic        ge;
        sh   = {rem, b};
        diff = sh - {1'b0, dvs};
        ge   = sh >= {1'b0, dvs};
        return {ge, ge ? diff[63:0] : sh[63:0]};
    endfunction

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic                 cur_vld;
        swc_pkg::div_side_t   cur_side;
        logic [QW-1:0]        cur_mq_x, cur_mq_y;
        logic [63:0]          cur_rem_x, cur_rem_y;
        logic [64:0]          step_x, step_y;
        logic [QW-1:0]        mq_x_next, mq_y_next;

        if (k == 0)
        begin : g_first
            assign cur_vld   = in_valid;
            assign cur_side  = in_side;
            assign cur_mq_x  = dvd_x;
            assign cur_mq_y  = dvd_y;
            assign cur_rem_x = '0;
            assign cur_rem_y = '0;
        end
        else
        begin : g_mid
            assign cur_vld   = vld_reg[k];
            assign cur_side  = side_reg[k];
            assign cur_mq_x  = mq_x_reg[k];
            assign cur_mq_y  = mq_y_reg[k];
            assign cur_rem_x = rem_x_reg[k];
            assign cur_rem_y = rem_y_reg[k];
        end

        always_comb
        begin
            step_x    = div_step(cur_rem_x, cur_mq_x[QW-1], dvs_x);
            step_y    = div_step(cur_rem_y, cur_mq_y[QW-1], dvs_y);
            mq_x_next = {cur_mq_x[QW-2:0], step_x[64]};
            mq_y_next = {cur_mq_y[QW-2:0], step_y[64]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= cur_side;
                mq_x_reg[k+1] <= mq_x_next;
                mq_y_reg[k+1] <= mq_y_next;
            end
        end

        if (k < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_x_reg[k+1] <= step_x[63:0];
                    rem_y_reg[k+1] <= step_y[63:0];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_side  = side_reg[QW];
    assign quo_x     = mq_x_reg[QW];
    assign quo_y     = mq_y_reg[QW];

endmodule

[rtl/screen_world_coordinate_map.sv]
// ----------------------------------------------------------------------------
// screen_world_coordinate_map: pixel <-> logical coordinate transform
// Rotate, scale and translate between window pixels and plot values.
// ----------------------------------------------------------------------------
// Usage:
//   point  : one item per point; operation 0 maps in_px/in_py (Q16.16) to
//            logical values, operation 1 maps in_lx/in_ly (Q32.32) to pixels.
//   result : one item per point; the fields of the other operation are zero,
//            status is ok, saturated, or zero scale (inverse only).
//   APB    : eight registers at byte address 8*i, 64-bit data; reads return the
//            stored value. Write only while no item is in flight (not enforced).
// Throughput: one item per clock, back to back, in both directions, unless stalled.
// Pipeline: the inverse divider, one quotient bit per stage over 81 stages,
//   sits between 3 stages in front and 6 behind it; forward items ride the
//   same pipeline so order is always kept.
// Stall: the whole pipeline holds while the output register is full and the
//   receiver is not ready; point.ready drops for exactly those cycles.
// Reset: all valid bits clear, registers return to identity (cos 1.0, scales
//   1.0, midpoints and window size 0). No clearing pass is needed.
// ----------------------------------------------------------------------------
module screen_world_coordinate_map (
    input  logic                  clk,
    input  logic                  rst_n,
    swc_point_if.sink             point,
    swc_result_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    localparam int QW  = swc_pkg::QW;
    localparam int RXW = swc_pkg::RXW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] win_width_reg, win_height_reg;
    logic [31:0] cos_reg, sin_reg;
    logic [63:0] sx_reg, sy_reg, mx_reg, my_reg;

    swc_pkg::reg_idx_t cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = swc_pkg::reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_width_reg  <= '0;
            win_height_reg <= '0;
            cos_reg        <= swc_pkg::COS_RESET;
            sin_reg        <= '0;
            sx_reg         <= swc_pkg::SCALE_RESET;
            sy_reg         <= swc_pkg::SCALE_RESET;
            mx_reg         <= '0;
            my_reg         <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                swc_pkg::REG_WIN_WIDTH:  win_width_reg  <= pwdata[15:0];
                swc_pkg::REG_WIN_HEIGHT: win_height_reg <= pwdata[15:0];
                swc_pkg::REG_COS_TERM:   cos_reg        <= pwdata[31:0];
                swc_pkg::REG_SIN_TERM:   sin_reg        <= pwdata[31:0];
                swc_pkg::REG_X_UNITS:    sx_reg         <= pwdata;
                swc_pkg::REG_Y_UNITS:    sy_reg         <= pwdata;
                swc_pkg::REG_X_VIEW_MID: mx_reg         <= pwdata;
                swc_pkg::REG_Y_VIEW_MID: my_reg         <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            swc_pkg::REG_WIN_WIDTH:  prdata = {48'b0, win_width_reg};
            swc_pkg::REG_WIN_HEIGHT: prdata = {48'b0, win_height_reg};
            swc_pkg::REG_COS_TERM:   prdata = {{32{cos_reg[31]}}, cos_reg};
            swc_pkg::REG_SIN_TERM:   prdata = {{32{sin_reg[31]}}, sin_reg};
            swc_pkg::REG_X_UNITS:    prdata = sx_reg;
            swc_pkg::REG_Y_UNITS:    prdata = sy_reg;
            swc_pkg::REG_X_VIEW_MID: prdata = mx_reg;
            swc_pkg::REG_Y_VIEW_MID: prdata = my_reg;
        endcase
    end

    // Values derived from configuration, held stable in flight only by the user
    logic [30:0] cx, cy;
    logic [63:0] ms_x, ms_y;
    logic        zero_scale;

    assign cx         = {win_width_reg, 15'b0};
    assign cy         = {win_height_reg, 15'b0};
    assign ms_x       = sx_reg[63] ? (~sx_reg + 64'd1) : sx_reg;
    assign ms_y       = sy_reg[63] ? (~sy_reg + 64'd1) : sy_reg;
    assign zero_scale = (sx_reg == '0) || (sy_reg == '0);

    // Global advance: move everything when the output register can take an item
    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || result.ready;
    assign point.ready = en;

    // ------------------------------------------------------------------
    // Stage 1: window-relative pixel, logical minus midpoint
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    swc_pkg::op_t       s1_op_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic signed [64:0] s1_ex_reg, s1_ey_reg, s1_ex_next, s1_ey_next;

    always_comb
    begin
        s1_dx_next = $signed({point.in_px[31], point.in_px}) - $signed({2'b00, cx});
        s1_dy_next = $signed({2'b00, cy}) - $signed({point.in_py[31], point.in_py});
        s1_ex_next = $signed({point.in_lx[63], point.in_lx}) - $signed({mx_reg[63], mx_reg});
        s1_ey_next = $signed({point.in_ly[63], point.in_ly}) - $signed({my_reg[63], my_reg});
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation products (forward), rounded dividend magnitude (inverse)
    // ------------------------------------------------------------------
    logic               s2_valid_reg;
    swc_pkg::op_t       s2_op_reg;
    logic signed [64:0] s2_xc_reg, s2_ys_reg, s2_yc_reg, s2_xs_reg;
    logic signed [64:0] s2_xc_next, s2_ys_next, s2_yc_next, s2_xs_next;
    logic [QW-1:0]      s2_mx_reg, s2_my_reg, s2_mx_next, s2_my_next;
    logic               s2_negx_reg, s2_negy_reg;
    logic [QW-1:0]      num_x, num_y, half_x, half_y;

    always_comb
    begin
        s2_xc_next = s1_dx_reg * $signed(cos_reg);
        s2_ys_next = s1_dy_reg * $signed(sin_reg);
        s2_yc_next = s1_dy_reg * $signed(cos_reg);
        s2_xs_next = s1_dx_reg * $signed(sin_reg);
        num_x      = {s1_ex_reg, 16'b0};
        num_y      = {s1_ey_reg, 16'b0};
        half_x     = {18'b0, ms_x[63:1]};
        half_y     = {18'b0, ms_y[63:1]};
        // |num| + half, negation folded into the carry-in
        s2_mx_next = (s1_ex_reg[64] ? ~num_x : num_x) + half_x
                   + {{(QW-1){1'b0}}, s1_ex_reg[64]};
        s2_my_next = (s1_ey_reg[64] ? ~num_y : num_y) + half_y
                   + {{(QW-1){1'b0}}, s1_ey_reg[64]};
    end

    // ------------------------------------------------------------------
    // Stage 3: rotated pixel, rounded to Q16.16
    // ------------------------------------------------------------------
    logic               s3_valid_reg;
    logic signed [65:0] rxs, rys;
    swc_pkg::div_side_t s3_side_reg, s3_side_next;
    logic [QW-1:0]      s3_mx_reg, s3_my_reg;

    always_comb
    begin
        rxs = $signed({s2_xc_reg[64], s2_xc_reg}) - $signed({s2_ys_reg[64], s2_ys_reg})
            + $signed(66'h2000_0000);
        rys = $signed({s2_yc_reg[64], s2_yc_reg}) + $signed({s2_xs_reg[64], s2_xs_reg})
            + $signed(66'h2000_0000);
        s3_side_next.op    = s2_op_reg;
        s3_side_next.neg_x = s2_negx_reg;
        s3_side_next.neg_y = s2_negy_reg;
        s3_side_next.rx    = rxs[65:30];
        s3_side_next.ry    = rys[65:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= point.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= swc_pkg::op_t'(point.operation);
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_ex_reg   <= s1_ex_next;
            s1_ey_reg   <= s1_ey_next;
            s2_op_reg   <= s1_op_reg;
            s2_xc_reg   <= s2_xc_next;
            s2_ys_reg   <= s2_ys_next;
            s2_yc_reg   <= s2_yc_next;
            s2_xs_reg   <= s2_xs_next;
            s2_mx_reg   <= s2_mx_next;
            s2_my_reg   <= s2_my_next;
            s2_negx_reg <= s1_ex_reg[64];
            s2_negy_reg <= s1_ey_reg[64];
            s3_side_reg <= s3_side_next;
            s3_mx_reg   <= s2_mx_reg;
            s3_my_reg   <= s2_my_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: floor((|num| + |s|/2) / |s|), 81 stages
    // ------------------------------------------------------------------
    logic               div_valid;
    logic [QW-1:0]      quo_x, quo_y;
    swc_pkg::div_side_t div_side;

    swc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .dvd_x     (s3_mx_reg),
        .dvd_y     (s3_my_reg),
        .dvs_x     (ms_x),
        .dvs_y     (ms_y),
        .in_side   (s3_side_reg),
        .out_valid (div_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Q1: apply quotient sign, saturate to 64 bits
    // ------------------------------------------------------------------
    function automatic logic [64:0] quo_sat(input logic [QW-1:0] q, input logic neg);
        logic big;
        logic over;
        logic [63:0] v;
        big  = |q[QW-1:63];
        // magnitude 2^63 still fits when negative
        over = neg ? (big && (q != ({{(QW-1){1'b0}}, 1'b1} << 63))) : big;
        if (over)
        begin
            v = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            v = neg ? (~q[63:0] + 64'd1) : q[63:0];
        end
        return {over, v};
    endfunction

    logic               q1_valid_reg;
    swc_pkg::op_t       q1_op_reg;
    logic               q1_sat_reg;
    logic [63:0]        q1_qx_reg, q1_qy_reg;
    logic signed [RXW-1:0] q1_rx_reg, q1_ry_reg;
    logic [64:0]        qsx, qsy;

    always_comb
    begin
        qsx = quo_sat(quo_x, div_side.neg_x ^ sx_reg[63]);
        qsy = quo_sat(quo_y, div_side.neg_y ^ sy_reg[63]);
    end

    // ------------------------------------------------------------------
    // Q2-Q3: split multipliers (scale forward, back-rotation inverse)
    // ------------------------------------------------------------------
    logic signed [RXW+63:0] f_x, f_y;
    logic signed [95:0]     m_xc, m_ys, m_yc, m_xs;

    swc_mul #(.WA(RXW)) u_mul_fx (.clk(clk), .en(en), .a(q1_rx_reg),
                                  .b($signed(sx_reg)), .p(f_x));
    swc_mul #(.WA(RXW)) u_mul_fy (.clk(clk), .en(en), .a(q1_ry_reg),
                                  .b($signed(sy_reg)), .p(f_y));
    swc_mul #(.WA(32))  u_mul_xc (.clk(clk), .en(en), .a($signed(cos_reg)),
                                  .b($signed(q1_qx_reg)), .p(m_xc));
    swc_mul #(.WA(32))  u_mul_ys (.clk(clk), .en(en), .a($signed(sin_reg)),
                                  .b($signed(q1_qy_reg)), .p(m_ys));
    swc_mul #(.WA(32))  u_mul_yc (.clk(clk), .en(en), .a($signed(cos_reg)),
                                  .b($signed(q1_qy_reg)), .p(m_yc));
    swc_mul #(.WA(32))  u_mul_xs (.clk(clk), .en(en), .a($signed(sin_reg)),
                                  .b($signed(q1_qx_reg)), .p(m_xs));

    logic         q2_valid_reg, q3_valid_reg;
    swc_pkg::op_t q2_op_reg, q3_op_reg;
    logic         q2_sat_reg, q3_sat_reg;

    // ------------------------------------------------------------------
    // Q4: add rounding constants (and the second rotation product)
    // ------------------------------------------------------------------
    logic               q4_valid_reg;
    swc_pkg::op_t       q4_op_reg;
    logic               q4_sat_reg;
    logic signed [97:0] q4_tx_reg, q4_ty_reg, q4_tx_next, q4_ty_next;
    logic signed [RXW+64:0] q4_fx_reg, q4_fy_reg, q4_fx_next, q4_fy_next;

    always_comb
    begin
        q4_tx_next = $signed({{2{m_xc[95]}}, m_xc}) + $signed({{2{m_ys[95]}}, m_ys})
                   + $signed(98'h2000_0000);
        q4_ty_next = $signed({{2{m_yc[95]}}, m_yc}) - $signed({{2{m_xs[95]}}, m_xs})
                   + $signed(98'h2000_0000);
        q4_fx_next = $signed({f_x[RXW+63], f_x}) + $signed({{(RXW+49){1'b0}}, 16'h8000});
        q4_fy_next = $signed({f_y[RXW+63], f_y}) + $signed({{(RXW+49){1'b0}}, 16'h8000});
    end

    // ------------------------------------------------------------------
    // Q5: shift out fraction, add window centre or view midpoint
    // ------------------------------------------------------------------
    logic               q5_valid_reg;
    swc_pkg::op_t       q5_op_reg;
    logic               q5_sat_reg;
    logic signed [68:0] q5_px_reg, q5_py_reg, q5_px_next, q5_py_next;
    logic signed [RXW+49:0] q5_lx_reg, q5_ly_reg, q5_lx_next, q5_ly_next;
    logic signed [67:0] ri_x, ri_y;
    logic signed [RXW+48:0] fl_x, fl_y;

    always_comb
    begin
        ri_x       = q4_tx_reg[97:30];
        ri_y       = q4_ty_reg[97:30];
        q5_px_next = $signed({ri_x[67], ri_x}) + $signed({38'b0, cx});
        q5_py_next = $signed({38'b0, cy}) - $signed({ri_y[67], ri_y});
        fl_x       = q4_fx_reg[RXW+64:16];
        fl_y       = q4_fy_reg[RXW+64:16];
        q5_lx_next = $signed({fl_x[RXW+48], fl_x})
                   + $signed({{(RXW-14){mx_reg[63]}}, mx_reg});
        q5_ly_next = $signed({fl_y[RXW+48], fl_y})
                   + $signed({{(RXW-14){my_reg[63]}}, my_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
            q3_valid_reg <= 1'b0;
            q4_valid_reg <= 1'b0;
            q5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            q1_valid_reg <= div_valid;
            q2_valid_reg <= q1_valid_reg;
            q3_valid_reg <= q2_valid_reg;
            q4_valid_reg <= q3_valid_reg;
            q5_valid_reg <= q4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_op_reg  <= div_side.op;
            // quotient overflow only counts for the inverse
            q1_sat_reg <= (div_side.op == swc_pkg::OP_TO_PIXEL) && (qsx[64] || qsy[64]);
            q1_qx_reg  <= qsx[63:0];
            q1_qy_reg  <= qsy[63:0];
            q1_rx_reg  <= div_side.rx;
            q1_ry_reg  <= div_side.ry;
            q2_op_reg  <= q1_op_reg;
            q2_sat_reg <= q1_sat_reg;
            q3_op_reg  <= q2_op_reg;
            q3_sat_reg <= q2_sat_reg;
            q4_op_reg  <= q3_op_reg;
            q4_sat_reg <= q3_sat_reg;
            q4_tx_reg  <= q4_tx_next;
            q4_ty_reg  <= q4_ty_next;
            q4_fx_reg  <= q4_fx_next;
            q4_fy_reg  <= q4_fy_next;
            q5_op_reg  <= q4_op_reg;
            q5_sat_reg <= q4_sat_reg;
            q5_px_reg  <= q5_px_next;
            q5_py_reg  <= q5_py_next;
            q5_lx_reg  <= q5_lx_next;
            q5_ly_reg  <= q5_ly_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: final saturation and status
    // ------------------------------------------------------------------
    function automatic logic [32:0] sat32(input logic [68:0] v);
        logic fits;
        fits = (&v[68:31]) || !(|v[68:31]);
        return {!fits, fits ? v[31:0] : (v[68] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    endfunction

    function automatic logic [64:0] sat64(input logic [RXW+49:0] v);
        logic fits;
        fits = (&v[RXW+49:63]) || !(|v[RXW+49:63]);
        return {!fits, fits ? v[63:0]
                            : (v[RXW+49] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)};
    endfunction

    logic [31:0]       out_px_reg, out_py_reg, out_px_next, out_py_next;
    logic [63:0]       out_lx_reg, out_ly_reg, out_lx_next, out_ly_next;
    swc_pkg::status_t  out_status_reg, out_status_next;
    logic [32:0]       spx, spy;
    logic [64:0]       slx, sly;

    always_comb
    begin
        spx = sat32(q5_px_reg);
        spy = sat32(q5_py_reg);
        slx = sat64(q5_lx_reg);
        sly = sat64(q5_ly_reg);
        out_px_next     = '0;
        out_py_next     = '0;
        out_lx_next     = '0;
        out_ly_next     = '0;
        out_status_next = swc_pkg::ST_OK;
        unique case (q5_op_reg)
            swc_pkg::OP_TO_LOGICAL:
            begin
                out_lx_next     = slx[63:0];
                out_ly_next     = sly[63:0];
                out_status_next = (slx[64] || sly[64]) ? swc_pkg::ST_SAT : swc_pkg::ST_OK;
            end
            swc_pkg::OP_TO_PIXEL:
            begin
                // a zero scale drops the whole pixel result
                if (zero_scale)
                begin
                    out_status_next = swc_pkg::ST_ZERO_SCALE;
                end
                else
                begin
                    out_px_next     = spx[31:0];
                    out_py_next     = spy[31:0];
                    out_status_next = (q5_sat_reg || spx[32] || spy[32])
                                    ? swc_pkg::ST_SAT : swc_pkg::ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= q5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_px_reg     <= out_px_next;
            out_py_reg     <= out_py_next;
            out_lx_reg     <= out_lx_next;
            out_ly_reg     <= out_ly_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.out_px = out_px_reg;
    assign result.out_py = out_py_reg;
    assign result.out_lx = out_lx_reg;
    assign result.out_ly = out_ly_reg;
    assign result.status = out_status_reg;

`ifndef SYNTH
    a_zero_scale_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == swc_pkg::ST_ZERO_SCALE) |->
        (result.out_px == '0) && (result.out_py == '0) &&
        (result.out_lx == '0) && (result.out_ly == '0))
        else $error("zero-scale item carries nonzero fields");

    a_one_side_only: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        ((result.out_px == '0) && (result.out_py == '0)) ||
        ((result.out_lx == '0) && (result.out_ly == '0)))
        else $error("pixel and logical fields both set");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(q5_valid_reg) && $stable(div_valid) && $stable(s1_valid_reg))
        else $error("pipeline moved during stall");

    a_quo_sat_inverse: assert property (@(posedge clk) disable iff (!rst_n)
        q1_valid_reg && (q1_op_reg == swc_pkg::OP_TO_LOGICAL) |-> !q1_sat_reg)
        else $error("quotient saturation flagged on forward item");
`endif

endmodule

[tb/screen_world_coordinate_map_test.sv]
// ----------------------------------------------------------------------------
// screen_world_coordinate_map_test: self-checking bench of the coordinate map
// Drives points in both directions through the item channels, programs the
// transform over APB between phases, and compares every result item field by
// field against an in-bench fixed-point model of the rotate/scale/translate.
// ----------------------------------------------------------------------------
module screen_world_coordinate_map_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Hold the run well under this many cycles; a correct run needs far fewer.
    localparam int CYCLE_LIMIT   = 400000;
    // Settle time after draining, longer than the pipeline depth of the block.
    localparam int DRAIN_CYCLES  = 100;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 110;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [63:0] lx;
        logic signed [63:0] ly;
        swc_pkg::status_t   status;
    } coord_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    swc_point_if  point_ch ();
    swc_result_if result_ch ();

    screen_world_coordinate_map dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .point   (point_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bench copy of the transform registers
    logic [15:0]        win_w;
    logic [15:0]        win_h;
    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;
    logic signed [63:0] x_scale;
    logic signed [63:0] y_scale;
    logic signed [63:0] x_mid;
    logic signed [63:0] y_mid;

    coord_result_t pending_results[$];
    int            error_count;
    int            cycle_count;
    int            sender_gap_max;
    int            stall_max;
    int            stall_left;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------

    // Round to nearest, ties toward plus infinity, drop n fraction bits
    function automatic wide_t round_shift(wide_t a, int n);
        wide_t half;
        half = wide_t'(1) <<< (n - 1);
        return (a + half) >>> n;
    endfunction

    function automatic logic signed [63:0] clamp64(wide_t a, ref bit sat);
        wide_t hi_lim;
        wide_t lo_lim;
        hi_lim = wide_t'(64'sh7FFF_FFFF_FFFF_FFFF);
        lo_lim = -hi_lim - 1;
        if (a > hi_lim)
        begin
            sat = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        if (a < lo_lim)
        begin
            sat = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return a[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(wide_t a, ref bit sat);
        if (a > wide_t'(32'sh7FFF_FFFF))
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (a < wide_t'(32'sh8000_0000))
        begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return a[31:0];
    endfunction

    // num / s rounded to nearest, ties away from zero
    function automatic wide_t divide_round(wide_t num, logic signed [63:0] s);
        wide_t       s_wide;
        logic [127:0] mag_n;
        logic [127:0] mag_s;
        logic [127:0] quo;
        s_wide = s;
        mag_n  = (num < 0) ? -num : num;
        mag_s  = (s_wide < 0) ? -s_wide : s_wide;
        quo    = (mag_n + (mag_s >> 1)) / mag_s;
        if ((num < 0) != (s < 0))
            return -$signed(quo);
        return $signed(quo);
    endfunction

    // Pixel (Q16.16) to logical value (Q32.32)
    function automatic coord_result_t map_to_logical(logic signed [31:0] px,
                                                     logic signed [31:0] py);
        coord_result_t r;
        wide_t         cx;
        wide_t         cy;
        wide_t         dx;
        wide_t         dy;
        wide_t         rx;
        wide_t         ry;
        bit            sat;
        sat = 1'b0;
        cx  = wide_t'({win_w, 15'b0});
        cy  = wide_t'({win_h, 15'b0});
        dx  = wide_t'(px) - cx;
        dy  = cy - wide_t'(py);
        rx  = round_shift(dx * wide_t'(cos_q30) - dy * wide_t'(sin_q30), 30);
        ry  = round_shift(dy * wide_t'(cos_q30) + dx * wide_t'(sin_q30), 30);
        r.px = '0;
        r.py = '0;
        r.lx = clamp64(round_shift(rx * wide_t'(x_scale), 16) + wide_t'(x_mid), sat);
        r.ly = clamp64(round_shift(ry * wide_t'(y_scale), 16) + wide_t'(y_mid), sat);
        r.status = sat ? swc_pkg::ST_SAT : swc_pkg::ST_OK;
        return r;
    endfunction

    // Logical value (Q32.32) to pixel (Q16.16)
    function automatic coord_result_t map_to_pixel(logic signed [63:0] lx,
                                                   logic signed [63:0] ly);
        coord_result_t      r;
        logic signed [63:0] qx;
        logic signed [63:0] qy;
        wide_t              rx;
        wide_t              ry;
        bit                 sat;
        sat  = 1'b0;
        r.px = '0;
        r.py = '0;
        r.lx = '0;
        r.ly = '0;
        if (x_scale == 0 || y_scale == 0)
        begin
            r.status = swc_pkg::ST_ZERO_SCALE;
            return r;
        end
        qx = clamp64(divide_round((wide_t'(lx) - wide_t'(x_mid)) <<< 16, x_scale), sat);
        qy = clamp64(divide_round((wide_t'(ly) - wide_t'(y_mid)) <<< 16, y_scale), sat);
        rx = round_shift(wide_t'(qx) * wide_t'(cos_q30) + wide_t'(qy) * wide_t'(sin_q30), 30);
        ry = round_shift(wide_t'(qy) * wide_t'(cos_q30) - wide_t'(qx) * wide_t'(sin_q30), 30);
        r.px = clamp32(rx + wide_t'({win_w, 15'b0}), sat);
        r.py = clamp32(wide_t'({win_h, 15'b0}) - ry, sat);
        r.status = sat ? swc_pkg::ST_SAT : swc_pkg::ST_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // APB write with a setup and an access phase; the register takes the value at the access edge.
    task automatic write_register(swc_pkg::reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            swc_pkg::REG_WIN_WIDTH:  win_w   = value[15:0];
            swc_pkg::REG_WIN_HEIGHT: win_h   = value[15:0];
            swc_pkg::REG_COS_TERM:   cos_q30 = value[31:0];
            swc_pkg::REG_SIN_TERM:   sin_q30 = value[31:0];
            swc_pkg::REG_X_UNITS:    x_scale = value;
            swc_pkg::REG_Y_UNITS:    y_scale = value;
            swc_pkg::REG_X_VIEW_MID: x_mid   = value;
            default:                 y_mid   = value;
        endcase
    endtask

    task automatic load_transform(logic [15:0] w, logic [15:0] h,
                                  logic signed [31:0] c, logic signed [31:0] s,
                                  logic signed [63:0] sx, logic signed [63:0] sy,
                                  logic signed [63:0] mx, logic signed [63:0] my);
        write_register(swc_pkg::REG_WIN_WIDTH, 64'(w));
        write_register(swc_pkg::REG_WIN_HEIGHT, 64'(h));
        write_register(swc_pkg::REG_COS_TERM, 64'(c));
        write_register(swc_pkg::REG_SIN_TERM, 64'(s));
        write_register(swc_pkg::REG_X_UNITS, sx);
        write_register(swc_pkg::REG_Y_UNITS, sy);
        write_register(swc_pkg::REG_X_VIEW_MID, mx);
        write_register(swc_pkg::REG_Y_VIEW_MID, my);
    endtask

    // Send one item; valid stays high on return so a back-to-back item
    // follows without a bubble. The expectation is queued at acceptance.
    task automatic send_point(swc_pkg::op_t op, logic signed [31:0] px,
                              logic signed [31:0] py,
                              logic signed [63:0] lx, logic signed [63:0] ly);
        coord_result_t expected;
        int            gap;
        expected = (op == swc_pkg::OP_TO_LOGICAL) ? map_to_logical(px, py)
                                                  : map_to_pixel(lx, ly);
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid     <= 1'b1;
        point_ch.operation <= op;
        point_ch.in_px     <= px;
        point_ch.in_py     <= py;
        point_ch.in_lx     <= lx;
        point_ch.in_ly     <= ly;
        do
            @(posedge clk);
        while (!point_ch.ready);
        pending_results.push_back(expected);
    endtask

    // Drop valid at the accepting edge of the last item and wait until every
    // expected result is back, then let the pipeline settle before touching
    // the registers.
    task automatic drain_pipeline();
        point_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random value sources
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [31:0] rand_trig();
        case ($urandom_range(0, 5))
            0:       return 32'sh4000_0000;
            1:       return -32'sh4000_0000;
            2:       return '0;
            3:       return $urandom;  // out of range, used as given
            default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        endcase
    endfunction

    function automatic logic signed [63:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return 64'sh0000_0001_0000_0000;
            1:       return -64'sh0000_0001_0000_0000;
            2:       return 64'sh8000_0000_0000_0000;
            3:       return 64'sh7FFF_FFFF_FFFF_FFFF;
            4:       return rand64();
            5:       return $signed(64'($urandom_range(1, 255)));
            default: return $signed({{24{$urandom_range(0, 1) == 1}}, 8'($urandom), $urandom});
        endcase
    endfunction

    function automatic logic signed [63:0] rand_mid();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return rand64();
            default: return $signed({{20{$urandom_range(0, 1) == 1}}, 12'($urandom), $urandom});
        endcase
    endfunction

    // Logical input: mostly near the view midpoint so results land in the
    // window, the rest anywhere in range.
    function automatic logic signed [63:0] rand_logical(logic signed [63:0] mid);
        if ($urandom_range(0, 3) == 0)
            return rand64();
        return mid + $signed({{24{$urandom_range(0, 1) == 1}}, 8'($urandom), $urandom});
    endfunction

    function automatic logic signed [31:0] rand_pixel(logic [15:0] extent);
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return $signed({1'b0, 15'($urandom_range(0, extent)), 16'($urandom)});
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, compare each result with the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        coord_result_t exp_r;
        int            next_stall;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      = 0;
        end
        else
        begin
            next_stall = stall_left;
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result item with nothing expected: px %h py %h lx %h ly %h st %0d",
                             $time, result_ch.out_px, result_ch.out_py, result_ch.out_lx,
                             result_ch.out_ly, result_ch.status);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result_ch.out_px !== exp_r.px)
                    begin
                        $display("%0t: out_px expected %h actual %h", $time, exp_r.px,
                                 result_ch.out_px);
                        error_count++;
                    end
                    if (result_ch.out_py !== exp_r.py)
                    begin
                        $display("%0t: out_py expected %h actual %h", $time, exp_r.py,
                                 result_ch.out_py);
                        error_count++;
                    end
                    if (result_ch.out_lx !== exp_r.lx)
                    begin
                        $display("%0t: out_lx expected %h actual %h", $time, exp_r.lx,
                                 result_ch.out_lx);
                        error_count++;
                    end
                    if (result_ch.out_ly !== exp_r.ly)
                    begin
                        $display("%0t: out_ly expected %h actual %h", $time, exp_r.ly,
                                 result_ch.out_ly);
                        error_count++;
                    end
                    if (result_ch.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                                 result_ch.status);
                        error_count++;
                    end
                end
                next_stall = $urandom_range(0, stall_max);
            end
            if (next_stall > 0)
            begin
                stall_left      = next_stall - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left      = 0;
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identity transform straight out of reset, field extremes both ways.
    task automatic test_reset_identity();
        send_point(swc_pkg::OP_TO_LOGICAL, '0, '0, '0, '0);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh8000_0000, 32'sh7FFF_FFFF, '1, '1);
        send_point(swc_pkg::OP_TO_PIXEL, '1, '1, '0, '0);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh7FFF_FFFF_FFFF_FFFF,
                   64'sh8000_0000_0000_0000);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh0000_0001_8000_0000,
                   -64'sh0000_0000_8000_0000);
        drain_pipeline();
    endtask

    // Full window, rotation and mirroring; huge scales push both paths
    // into saturation, half-pixel values exercise the rounding ties.
    task automatic test_rotation_saturation();
        load_transform(16'hFFFF, 16'hFFFF, '0, 32'sh4000_0000,
                       -64'sh0000_0001_0000_0000, 64'sh0000_0002_0000_0000,
                       64'sh0000_0010_0000_0000, -64'sh0000_0010_0000_0000);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh0000_8000, 32'sh0000_8000, '0, '0);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh0000_0010_0000_0001,
                   64'sh8000_0000_0000_0000);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh7FFF_FFFF_FFFF_FFFF, '0);
        drain_pipeline();
        load_transform('0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
                       64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh0000_0001, '0, '0, '0);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh8000_0000_0000_0000,
                   64'sh7FFF_FFFF_FFFF_FFFF);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, '0, '0);
        drain_pipeline();
        // Tiny scale: the inverse quotient overflows and clamps
        load_transform(16'd640, 16'd480, -32'sh4000_0000, '0,
                       64'sh1, -64'sh1, '0, '0);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh0000_7FFF_0000_0000,
                   -64'sh0000_0001_0000_0000);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh1, -64'sh1);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh0140_0000, 32'sh00F0_0000, '0, '0);
        drain_pipeline();
    endtask

    // A zero scale on either axis makes every inverse item a divide error;
    // the forward path still maps normally.
    task automatic test_zero_scale();
        load_transform(16'd100, 16'd50, 32'sh4000_0000, '0, '0,
                       64'sh0000_0001_0000_0000, '0, '0);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, 64'sh0000_0005_0000_0000, 64'sh3);
        send_point(swc_pkg::OP_TO_LOGICAL, 32'sh0010_0000, 32'sh0020_0000, '0, '0);
        drain_pipeline();
        write_register(swc_pkg::REG_X_UNITS, 64'sh0000_0001_0000_0000);
        write_register(swc_pkg::REG_Y_UNITS, '0);
        send_point(swc_pkg::OP_TO_PIXEL, '0, '0, '1, '1);
        send_point(swc_pkg::OP_TO_LOGICAL, '1, '1, '0, '0);
        drain_pipeline();
    endtask

    // Random phases: new transform, then a mix of both operations with
    // alternating burst and idling traffic on both sides.
    task automatic test_random_phases();
        logic [15:0]  w;
        logic [15:0]  h;
        swc_pkg::op_t op;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w = (p % 4 == 0) ? 16'hFFFF : 16'($urandom_range(0, 4096));
            h = (p % 4 == 1) ? 16'hFFFF : 16'($urandom);
            load_transform(w, h, rand_trig(), rand_trig(), rand_scale(), rand_scale(),
                           rand_mid(), rand_mid());
            sender_gap_max = (p % 3 == 0) ? 0 : 7;
            stall_max      = (p % 3 == 1) ? 0 : 7;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                op = swc_pkg::op_t'($urandom_range(0, 1));
                send_point(op, rand_pixel(w), rand_pixel(h),
                           rand_logical(x_mid), rand_logical(y_mid));
            end
            drain_pipeline();
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        point_ch.valid     = 1'b0;
        point_ch.operation = swc_pkg::OP_TO_LOGICAL;
        point_ch.in_px     = '0;
        point_ch.in_py     = '0;
        point_ch.in_lx     = '0;
        point_ch.in_ly     = '0;
        error_count        = 0;
        cycle_count        = 0;
        sender_gap_max     = 7;
        stall_max          = 7;
        // Reset values of the registers
        win_w   = '0;
        win_h   = '0;
        cos_q30 = swc_pkg::COS_RESET;
        sin_q30 = '0;
        x_scale = swc_pkg::SCALE_RESET;
        y_scale = swc_pkg::SCALE_RESET;
        x_mid   = '0;
        y_mid   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_identity();
        test_rotation_saturation();
        test_zero_scale();
        test_random_phases();

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/swc_pkg.sv
rtl/swc_if.sv
rtl/swc_mul.sv
rtl/swc_div.sv
rtl/screen_world_coordinate_map.sv
tb/screen_world_coordinate_map_test.sv
